@@ rtl/core/tmsf_pkg.sv @@
// ----------------------------------------------------------------------------
// tmsf_pkg
// Shared sizes, constants and types of the trimmed mean slew filter.
// ----------------------------------------------------------------------------
package tmsf_pkg;

    // Fixed field widths.
    localparam int SAMPLE_W = 12;
    localparam int CHAN_W   = 3;

    // Block sizing.
    localparam int CHANNELS      = 6;
    localparam int WINDOW_LENGTH = 8;
    localparam int TRIM_START    = 2;
    localparam int TRIM_COUNT    = 4;

    // Part of the sorted slice that lies inside the window.
    localparam int SLICE_LO    = (TRIM_START < WINDOW_LENGTH) ? TRIM_START : WINDOW_LENGTH;
    localparam int SLICE_END   = TRIM_START + TRIM_COUNT;
    localparam int SLICE_HI    = (SLICE_END < WINDOW_LENGTH) ? SLICE_END : WINDOW_LENGTH;
    localparam int SLICE_USED  = (SLICE_HI > SLICE_LO) ? (SLICE_HI - SLICE_LO) : 0;
    localparam int DIV_D       = (SLICE_USED > 0) ? SLICE_USED : 1;

    // Accumulator and exact reciprocal for the division by the slice length.
    localparam int SUM_W       = SAMPLE_W + $clog2(DIV_D);
    localparam int RECIP_SHIFT = SUM_W + $clog2(DIV_D);
    localparam int RECIP_W     = SUM_W + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DIV_D) - 64'd1) / 64'(DIV_D));

    // Window memory addressing.
    localparam int SLOT_W    = $clog2(WINDOW_LENGTH);
    localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int WIN_DEPTH = CHANNELS * WINDOW_LENGTH;
    localparam int ADDR_W    = $clog2(WIN_DEPTH);

    // Register reset value.
    localparam logic [SAMPLE_W-1:0] CEIL_RESET = 12'd1080;

    // Slew thresholds and step sizes.
    localparam logic [SAMPLE_W-1:0] GAP_T20 = 12'd400;
    localparam logic [SAMPLE_W-1:0] GAP_T10 = 12'd300;
    localparam logic [SAMPLE_W-1:0] GAP_T7  = 12'd200;
    localparam logic [SAMPLE_W-1:0] GAP_T5  = 12'd100;
    localparam logic [SAMPLE_W-1:0] GAP_T2  = 12'd50;
    localparam logic [4:0] STEP_20 = 5'd20;
    localparam logic [4:0] STEP_10 = 5'd10;
    localparam logic [4:0] STEP_7  = 5'd7;
    localparam logic [4:0] STEP_5  = 5'd5;
    localparam logic [4:0] STEP_2  = 5'd2;
    localparam logic [4:0] STEP_1  = 5'd1;

    typedef struct packed {
        logic [CHAN_W-1:0]   channel;
        logic [SAMPLE_W-1:0] sample;
    } in_word_t;

    typedef struct packed {
        logic [CHAN_W-1:0]   out_channel;
        logic [SAMPLE_W-1:0] filtered;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_LOAD,
        ST_DRAIN,
        ST_SORT,
        ST_SUM,
        ST_SCALE,
        ST_FINISH
    } tmsf_state_t;

    typedef struct packed {
        logic              accept;
        logic              write;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_slot;
        logic              acc_clear;
        logic              sort_en;
        logic              sort_odd;
        logic              acc_add;
        logic [SLOT_W-1:0] acc_idx;
        logic              scale;
        logic              finish;
    } tmsf_cmd_t;

    typedef struct packed {
        logic in_range;
        logic out_free;
    } tmsf_status_t;

endpackage

@@ rtl/core/tmsf_ctrl.sv @@
// ----------------------------------------------------------------------------
// tmsf_ctrl
// Sequencer that steps the datapath through write, load, drain, sort, sum, scale and slew.
// ----------------------------------------------------------------------------
module tmsf_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  tmsf_pkg::tmsf_status_t status,
    output tmsf_pkg::tmsf_cmd_t   cmd
);
    import tmsf_pkg::*;

    tmsf_state_t       state_reg;
    tmsf_state_t       state_next;
    logic [SLOT_W-1:0] cnt_reg;
    logic [SLOT_W-1:0] cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cnt_next = '0;
                if (status.in_range)
                begin
                    cmd.write  = 1'b1;
                    state_next = ST_LOAD;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_LOAD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_slot = cnt_reg;
                if (cnt_reg == SLOT_W'(WINDOW_LENGTH - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                cmd.acc_clear = 1'b1;
                state_next    = ST_SORT;
            end
            ST_SORT:
            begin
                cmd.sort_en  = 1'b1;
                cmd.sort_odd = cnt_reg[0];
                if (cnt_reg == SLOT_W'(WINDOW_LENGTH - 1))
                begin
                    cnt_next   = '0;
                    state_next = (SLICE_USED == 0) ? ST_FINISH : ST_SUM;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SUM:
            begin
                cmd.acc_add = 1'b1;
                cmd.acc_idx = SLOT_W'(SLICE_LO) + cnt_reg;
                if (cnt_reg == SLOT_W'(DIV_D - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_SCALE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/tmsf_datapath.sv @@
// ----------------------------------------------------------------------------
// tmsf_datapath
// Window memory, sort registers, slice accumulator, scaler and slew unit.
// ----------------------------------------------------------------------------
module tmsf_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tmsf_pkg::in_word_t     in_word,
    input  logic                   ceil_we,
    input  logic [11:0]            ceil_data,
    input  tmsf_pkg::tmsf_cmd_t    cmd,
    output tmsf_pkg::tmsf_status_t status,
    output logic                   out_valid,
    input  logic                   out_stall,
    output tmsf_pkg::out_word_t    out_word
);
    import tmsf_pkg::*;

    localparam logic [4:0] CHANNELS_C = 5'(CHANNELS);

    // Item registers.
    logic [CHAN_W-1:0]   ch_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                in_range_reg;
    logic [CH_IDX_W-1:0] ch_idx;

    // Configuration.
    logic [SAMPLE_W-1:0] ceil_reg;

    // Window memory with per-channel circular write pointer and fill flag.
    logic [SAMPLE_W-1:0] win_mem [WIN_DEPTH];
    logic [SLOT_W-1:0]   ptr_reg  [CHANNELS];
    logic                full_reg [CHANNELS];
    logic [ADDR_W-1:0]   row_base;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]   rd_addr;
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                rd_valid_reg;
    logic                slot_ok_reg;

    // Sort, sum and scale.
    logic [SAMPLE_W-1:0] work_reg [WINDOW_LENGTH];
    logic [SAMPLE_W-1:0] sorted   [WINDOW_LENGTH];
    logic [SUM_W-1:0]    acc_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [SAMPLE_W-1:0] mean;

    // Slew.
    logic [SAMPLE_W-1:0] last_reg [CHANNELS];
    logic [SAMPLE_W-1:0] old_val;
    logic                move_up;
    logic [SAMPLE_W-1:0] gap;
    logic [4:0]          adj;
    logic [SAMPLE_W:0]   up_sum;
    logic [SAMPLE_W-1:0] next_val;

    logic                out_valid_reg;
    out_word_t           out_word_reg;

    assign ch_idx   = CH_IDX_W'(ch_reg);
    assign row_base = ADDR_W'(ch_idx) * ADDR_W'(WINDOW_LENGTH);
    assign wr_addr  = row_base + ADDR_W'(ptr_reg[ch_idx]);
    assign rd_addr  = row_base + ADDR_W'(cmd.rd_slot);

    assign status.in_range = in_range_reg;
    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign out_word        = out_word_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            ch_reg       <= in_word.channel;
            sample_reg   <= in_word.sample;
            in_range_reg <= ({2'b00, in_word.channel} < CHANNELS_C);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ceil_reg <= CEIL_RESET;
        end
        else if (ceil_we)
        begin
            ceil_reg <= ceil_data;
        end
    end

    // The memory keeps each channel's window as a ring; the slice mean does not
    // depend on where a sample sits, only on which samples are present.
    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            win_mem[wr_addr] <= sample_reg;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= win_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                ptr_reg[c]  <= '0;
                full_reg[c] <= 1'b0;
            end
            rd_valid_reg <= 1'b0;
            slot_ok_reg  <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.rd_en;
            slot_ok_reg  <= full_reg[ch_idx] || (cmd.rd_slot < ptr_reg[ch_idx]);
            if (cmd.write)
            begin
                if (ptr_reg[ch_idx] == SLOT_W'(WINDOW_LENGTH - 1))
                begin
                    ptr_reg[ch_idx]  <= '0;
                    full_reg[ch_idx] <= 1'b1;
                end
                else
                begin
                    ptr_reg[ch_idx] <= ptr_reg[ch_idx] + 1'b1;
                end
            end
        end
    end

    // One odd-even transposition pass over the working copy.
    always_comb
    begin
        sorted = work_reg;
        for (int i = 0; i < WINDOW_LENGTH - 1; i++)
        begin
            if ((i[0] == cmd.sort_odd) && (work_reg[i] > work_reg[i + 1]))
            begin
                sorted[i]     = work_reg[i + 1];
                sorted[i + 1] = work_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_valid_reg)
        begin
            for (int i = 0; i < WINDOW_LENGTH - 1; i++)
            begin
                work_reg[i] <= work_reg[i + 1];
            end
            work_reg[WINDOW_LENGTH - 1] <= slot_ok_reg ? rd_data_reg : '0;
        end
        else if (cmd.sort_en)
        begin
            work_reg <= sorted;
        end

        if (cmd.acc_clear)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + SUM_W'(work_reg[cmd.acc_idx]);
        end

        if (cmd.scale)
        begin
            prod_reg <= PROD_W'(acc_reg) * PROD_W'(RECIP);
        end
    end

    assign mean = (SLICE_USED == 0) ? '0 : SAMPLE_W'(prod_reg >> RECIP_SHIFT);

    always_comb
    begin
        old_val = last_reg[ch_idx];
        move_up = mean > old_val;
        gap     = move_up ? (mean - old_val) : (old_val - mean);
        if (gap >= GAP_T20)
        begin
            adj = STEP_20;
        end
        else if (gap >= GAP_T10)
        begin
            adj = STEP_10;
        end
        else if (gap >= GAP_T7)
        begin
            adj = STEP_7;
        end
        else if (gap >= GAP_T5)
        begin
            adj = STEP_5;
        end
        else if (gap >= GAP_T2)
        begin
            adj = STEP_2;
        end
        else
        begin
            adj = STEP_1;
        end
        up_sum = {1'b0, old_val} + (SAMPLE_W + 1)'(adj);
        if (mean == old_val)
        begin
            next_val = old_val;
        end
        else if (move_up)
        begin
            next_val = (up_sum > {1'b0, ceil_reg}) ? ceil_reg : up_sum[SAMPLE_W-1:0];
        end
        else
        begin
            next_val = (old_val < SAMPLE_W'(adj)) ? '0 : (old_val - SAMPLE_W'(adj));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                last_reg[c] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                if (in_range_reg)
                begin
                    last_reg[ch_idx] <= next_val;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_word_reg.out_channel <= ch_reg;
            out_word_reg.filtered    <= in_range_reg ? next_val : '0;
        end
    end

endmodule

@@ rtl/core/trimmed_mean_slew_filter.sv @@
// ----------------------------------------------------------------------------
// trimmed_mean_slew_filter
// Per-channel sorted-window trimmed mean followed by a stepped slew limiter.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                    Word / data
//  -------   --------------------------   -----------------------------------
//  input     sample_valid / sample_stall  sample_word  (channel, sample)
//  output    result_valid / result_stall  result_word  (out_channel, filtered)
//  config    ceiling_we                   ceiling_data (output ceiling)
//
//  Each word is finished before the next is accepted; a word for an
//  unknown channel skips the window. The pace is set by the single-port
//  window memory, read one slot a cycle, and by the odd-even sort, one
//  pass a cycle over the working copy. Reset empties the windows through
//  their fill flags, clears the held outputs and sets the ceiling to its
//  reset value at once; no clearing pass is needed. The output register
//  lets a new word be accepted while a result is still stalled.
//
// The controller sequences every word; the datapath holds all the storage.
// Each channel's window is kept as a ring in memory, since the sorted slice
// does not depend on the order of the samples; a fill flag and write pointer
// per channel make slots that were never written read as zero.
// The slice mean divides by a fixed length, done as a multiply by an exact
// reciprocal followed by a shift.
module trimmed_mean_slew_filter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  tmsf_pkg::in_word_t  sample_word,
    output logic                result_valid,
    input  logic                result_stall,
    output tmsf_pkg::out_word_t result_word,
    input  logic                ceiling_we,
    input  logic [11:0]         ceiling_data
);
    import tmsf_pkg::*;

    tmsf_cmd_t    cmd;
    tmsf_status_t status;

    // The sequencer owns the input handshake and all step counting.
    tmsf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample_valid),
        .in_stall (sample_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath owns the state, the arithmetic and the output register.
    tmsf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (sample_word),
        .ceil_we   (ceiling_we),
        .ceil_data (ceiling_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (result_valid),
        .out_stall (result_stall),
        .out_word  (result_word)
    );

endmodule
